// File: src/esirkepov_current_deposit_4th_order_1d_assert.svh
// Assertion macros shared by the checker of the current deposit block.
// Needs clk and rst in the scope where a macro is used.
`ifndef ESIRKEPOV_CURRENT_DEPOSIT_4TH_ORDER_1D_ASSERT_SVH
`define ESIRKEPOV_CURRENT_DEPOSIT_4TH_ORDER_1D_ASSERT_SVH

// same-cycle implication
`define ECD4_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define ECD4_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: src/ecd4_pkg.sv
// Package of the 1D quartic current deposit block: types, constants, helpers.
// No dependencies.
`default_nettype none
package ecd4_pkg;

  localparam int GRID_CELLS_DEFAULT = 1024;
  localparam int STENCIL_CELLS      = 7;
  localparam int QUEUE_DEPTH        = 2;
  localparam int SHAPE_STEPS        = 10;
  localparam int DIV_BITS           = 52;

  localparam logic [23:0] GAMMA_ONE = 24'd65536;
  localparam logic signed [56:0] HALF_NODE = 57'sh8_0000_0000;

  localparam logic signed [31:0] Q30_1_384   = 32'sd2796203;
  localparam logic signed [31:0] Q30_1_48    = 32'sd22369621;
  localparam logic signed [31:0] Q30_1_12    = 32'sd89478485;
  localparam logic signed [31:0] Q30_1_24    = 32'sd44739243;
  localparam logic signed [31:0] Q30_19_96   = 32'sd212511403;
  localparam logic signed [31:0] Q30_11_24   = 32'sd492131669;
  localparam logic signed [31:0] Q30_1_6     = 32'sd178956971;
  localparam logic signed [31:0] Q30_115_192 = 32'sd643126613;
  localparam logic signed [31:0] Q30_5_8     = 32'sd671088640;

  // shape micro-steps, one product per lane each
  localparam logic [3:0] STEP_X2    = 4'd0;
  localparam logic [3:0] STEP_X3    = 4'd1;
  localparam logic [3:0] STEP_X4    = 4'd2;
  localparam logic [3:0] STEP_C48   = 4'd3;
  localparam logic [3:0] STEP_C12   = 4'd4;
  localparam logic [3:0] STEP_C24   = 4'd5;
  localparam logic [3:0] STEP_C1124 = 4'd6;
  localparam logic [3:0] STEP_C6X3  = 4'd7;
  localparam logic [3:0] STEP_C6X4  = 4'd8;
  localparam logic [3:0] STEP_C58   = 4'd9;

  typedef enum logic [1:0] {
    CFG_INV_CELL_LENGTH = 2'd0,
    CFG_CELL_PER_STEP   = 2'd1,
    CFG_DOMAIN_START    = 2'd2
  } cfg_index_t;

  typedef enum logic {
    KIND_DEPOSIT = 1'b0,
    KIND_READ    = 1'b1
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_LOC, ST_CHK,
    ST_SHAPE, ST_SUM, ST_WAIT, ST_CELL, ST_DRAIN
  } state_t;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] old_position;
    logic signed [31:0] new_position;
    logic signed [23:0] momentum_y;
    logic signed [23:0] momentum_z;
    logic        [23:0] lorentz_factor;
    logic signed [3:0]  particle_charge;
    logic        [23:0] particle_weight;
    logic        [9:0]  read_cell;
  } item_t;

  typedef struct packed {
    logic        [9:0]  cell_number;
    logic signed [31:0] current_x;
    logic signed [31:0] current_y;
    logic signed [31:0] current_z;
    logic signed [31:0] charge_density;
  } result_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [23:0] value;
  } cfg_t;

  typedef struct packed {
    kind_t kind;
    logic  read_ok;
    item_t item;
  } entry_t;

  typedef struct packed {
    logic               start;
    logic signed [51:0] num_y;
    logic signed [51:0] num_z;
    logic        [23:0] den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic signed [31:0] q_y;
    logic signed [31:0] q_z;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return 32'(v);
  endfunction

endpackage
`default_nettype wire

// File: src/ecd4_chan_if.sv
// Valid/ready channel carrying one payload of type T.
// No dependencies.
`default_nettype none
interface ecd4_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/ecd4_front.sv
// Front end: accepts items, tags them as deposit or read, queues them.
// Uses ecd4_pkg and ecd4_chan_if.
`default_nettype none
module ecd4_front import ecd4_pkg::*; #(
  parameter int GRID_CELLS = GRID_CELLS_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   clearing,
  ecd4_chan_if.sink items,
  output logic   q_valid,
  input  logic   q_ready,
  output entry_t q_entry
);
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t         slots [QUEUE_DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           pop;
  entry_t         tagged_in;

  assign items.ready = !clearing && (count != CW'(QUEUE_DEPTH));
  assign push        = items.valid && items.ready;
  assign q_valid     = (count != '0);
  assign pop         = q_valid && q_ready;
  assign q_entry     = slots[rptr];

  always_comb begin
    tagged_in.kind    = items.data.mode ? KIND_READ : KIND_DEPOSIT;
    tagged_in.read_ok = int'(items.data.read_cell) < GRID_CELLS;
    tagged_in.item    = items.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= tagged_in;
  end
endmodule
`default_nettype wire

// File: src/ecd4_div.sv
// Two-lane restoring divider, one quotient bit per cycle, signed truncating.
// Uses ecd4_pkg.
`default_nettype none
module ecd4_div import ecd4_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  localparam int CW = $clog2(DIV_BITS + 1);

  logic                busy;
  logic [CW-1:0]       cnt;
  logic [23:0]         den;
  logic                neg  [2];
  logic [DIV_BITS-1:0] mag  [2];
  logic [23:0]         rem  [2];
  logic signed [51:0]  num  [2];
  logic [25:0]         trial[2];
  logic signed [52:0]  quo  [2];

  always_comb begin
    num[0] = req.num_y;
    num[1] = req.num_z;
    for (int l = 0; l < 2; l++) begin
      trial[l] = {1'b0, rem[l], mag[l][DIV_BITS-1]} - {2'b0, den};
      quo[l]   = neg[l] ? -$signed({1'b0, mag[l]}) : $signed({1'b0, mag[l]});
    end
    rsp.busy = busy;
    rsp.q_y  = sat32(64'(quo[0]));
    rsp.q_z  = sat32(64'(quo[1]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CW'(DIV_BITS - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      den <= req.den;
      for (int l = 0; l < 2; l++) begin
        neg[l] <= num[l][51];
        mag[l] <= num[l][51] ? DIV_BITS'(-num[l]) : DIV_BITS'(num[l]);
        rem[l] <= '0;
      end
    end else if (busy) begin
      for (int l = 0; l < 2; l++) begin
        if (!trial[l][25]) begin
          rem[l] <= trial[l][23:0];
          mag[l] <= {mag[l][DIV_BITS-2:0], 1'b1};
        end else begin
          rem[l] <= {rem[l][22:0], mag[l][DIV_BITS-1]};
          mag[l] <= {mag[l][DIV_BITS-2:0], 1'b0};
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: src/ecd4_back.sv
// Back end: sequencer for locate, shape, cell read-modify-write and reads;
// holds the grid memories, config registers and result register. Uses ecd4_pkg.
`default_nettype none
module ecd4_back import ecd4_pkg::*; #(
  parameter int GRID_CELLS = GRID_CELLS_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_valid,
  output logic     q_ready,
  input  entry_t   q_entry,
  input  logic     cfg_we,
  input  cfg_t     cfg_data,
  output logic     clearing,
  output div_req_t div_req,
  input  div_rsp_t div_rsp,
  ecd4_chan_if.source results
);
  localparam int AW = $clog2(GRID_CELLS);
  localparam logic signed [22:0] BASE_MAX = 23'(GRID_CELLS - STENCIL_CELLS);

  state_t state, state_next;
  logic [AW-1:0] clr_addr;
  logic [3:0]    step;
  logic [2:0]    cell_idx;

  logic [23:0] inv_len;
  logic [23:0] cps;
  logic [19:0] dom;

  item_t              it;
  logic               rd_ok;
  logic signed [27:0] cw;
  logic signed [56:0] g_o, g_n;
  logic signed [52:0] cxp;
  logic signed [51:0] ny, nz;
  logic signed [29:0] x_lane [2];
  logic signed [1:0]  diff_r;
  logic [AW-1:0]      base_r;
  logic signed [31:0] crx, cry, crz;
  logic signed [31:0] term [2][SHAPE_STEPS];
  logic signed [31:0] shp  [2][5];
  logic signed [33:0] cum;

  logic               acc_valid;
  logic [AW-1:0]      acc_addr;
  logic signed [35:0] inc_x, inc_y, inc_z, inc_r;

  logic signed [31:0] mem_x [GRID_CELLS];
  logic signed [31:0] mem_y [GRID_CELLS];
  logic signed [31:0] mem_z [GRID_CELLS];
  logic signed [31:0] mem_r [GRID_CELLS];
  logic signed [31:0] rd_x, rd_y, rd_z, rd_r;

  logic               res_valid;
  result_t            res_data;

  // comb
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_x, wr_y, wr_z, wr_r;
  logic               res_load;
  logic signed [56:0] t_o, t_n;
  logic signed [20:0] n_o, n_n;
  logic signed [21:0] diff;
  logic signed [22:0] base;
  logic               drop;
  logic signed [31:0] op_a [2];
  logic signed [31:0] op_b [2];
  logic signed [63:0] prod [2];
  logic signed [31:0] sums [2][5];
  logic signed [31:0] s0i, s1i, wt;
  logic signed [32:0] wsum;
  logic signed [4:0]  jidx;
  logic signed [65:0] px;
  logic signed [63:0] py, pz, pr;

  assign clearing      = (state == ST_CLEAR);
  assign results.valid = res_valid;
  assign results.data  = res_data;

  // locate and range check
  always_comb begin
    t_o  = g_o + HALF_NODE;
    t_n  = g_n + HALF_NODE;
    n_o  = t_o[56:36];
    n_n  = t_n[56:36];
    diff = 22'(n_n) - 22'(n_o);
    base = 23'(n_o) - $signed({3'b0, dom}) - 23'sd3;
    drop = (diff > 22'sd1) || (diff < -22'sd1) || (base < 23'sd0) || (base > BASE_MAX);
  end

  // shape products, one per lane per step
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      case (step)
        STEP_X2:    begin op_a[l] = 32'(x_lane[l]);         op_b[l] = 32'(x_lane[l]); end
        STEP_X3:    begin op_a[l] = term[l][STEP_X2];       op_b[l] = 32'(x_lane[l]); end
        STEP_X4:    begin op_a[l] = term[l][STEP_X3];       op_b[l] = 32'(x_lane[l]); end
        STEP_C48:   begin op_a[l] = Q30_1_48;               op_b[l] = 32'(x_lane[l]); end
        STEP_C12:   begin op_a[l] = Q30_1_12;               op_b[l] = term[l][STEP_X3]; end
        STEP_C24:   begin op_a[l] = Q30_1_24;               op_b[l] = term[l][STEP_X4]; end
        STEP_C1124: begin op_a[l] = Q30_11_24;              op_b[l] = 32'(x_lane[l]); end
        STEP_C6X3:  begin op_a[l] = Q30_1_6;                op_b[l] = term[l][STEP_X3]; end
        STEP_C6X4:  begin op_a[l] = Q30_1_6;                op_b[l] = term[l][STEP_X4]; end
        STEP_C58:   begin op_a[l] = Q30_5_8;                op_b[l] = term[l][STEP_X2]; end
        default:    begin op_a[l] = '0;                     op_b[l] = '0; end
      endcase
      prod[l] = op_a[l] * op_b[l];
      sums[l][0] = Q30_1_384 - term[l][STEP_C48] + (term[l][STEP_X2] >>> 4)
                 - term[l][STEP_C12] + term[l][STEP_C24];
      sums[l][1] = Q30_19_96 - term[l][STEP_C1124] + (term[l][STEP_X2] >>> 2)
                 + term[l][STEP_C6X3] - term[l][STEP_C6X4];
      sums[l][2] = Q30_115_192 - term[l][STEP_C58] + (term[l][STEP_X4] >>> 2);
      sums[l][3] = Q30_19_96 + term[l][STEP_C1124] + (term[l][STEP_X2] >>> 2)
                 - term[l][STEP_C6X3] - term[l][STEP_C6X4];
      sums[l][4] = Q30_1_384 + term[l][STEP_C48] + (term[l][STEP_X2] >>> 4)
                 + term[l][STEP_C12] + term[l][STEP_C24];
    end
  end

  // stencil weights and products for the current cell
  always_comb begin
    s0i  = (cell_idx >= 3'd1 && cell_idx <= 3'd5) ? shp[0][3'(cell_idx - 3'd1)] : '0;
    jidx = $signed({2'b0, cell_idx}) - 5'sd1 - 5'(diff_r);
    s1i  = (jidx >= 5'sd0 && jidx <= 5'sd4) ? shp[1][jidx[2:0]] : '0;
    wsum = 33'(s0i) + 33'(s1i);
    wt   = 32'(wsum >>> 1);
    px   = crx * cum;
    py   = cry * wt;
    pz   = crz * wt;
    pr   = cw * s1i;
  end

  // accumulate with saturation, or write zeros while clearing
  always_comb begin
    wr_en   = clearing || acc_valid;
    wr_addr = clearing ? clr_addr : acc_addr;
    wr_x    = clearing ? '0 : sat32(64'(37'(rd_x) + 37'(inc_x)));
    wr_y    = clearing ? '0 : sat32(64'(37'(rd_y) + 37'(inc_y)));
    wr_z    = clearing ? '0 : sat32(64'(37'(rd_z) + 37'(inc_z)));
    wr_r    = clearing ? '0 : sat32(64'(37'(rd_r) + 37'(inc_r)));
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == AW'(GRID_CELLS - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (q_valid) state_next = (q_entry.kind == KIND_READ) ? ST_READ : ST_LOC;
      ST_READ:  if (!res_valid || results.ready) state_next = ST_IDLE;
      ST_LOC:   state_next = ST_CHK;
      ST_CHK:   state_next = drop ? ST_IDLE : ST_SHAPE;
      ST_SHAPE: if (step == 4'(SHAPE_STEPS - 1)) state_next = ST_SUM;
      ST_SUM:   state_next = ST_WAIT;
      ST_WAIT:  if (!div_rsp.busy) state_next = ST_CELL;
      ST_CELL:  if (cell_idx == 3'(STENCIL_CELLS - 1)) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    q_ready = (state == ST_IDLE);
    rd_en   = 1'b0;
    rd_addr = base_r + AW'(cell_idx);
    if (state == ST_IDLE) begin
      rd_en   = q_valid && (q_entry.kind == KIND_READ) && q_entry.read_ok;
      rd_addr = AW'(q_entry.item.read_cell);
    end else if (state == ST_CELL) begin
      rd_en = 1'b1;
    end
    res_load      = (state == ST_READ) && (!res_valid || results.ready);
    div_req.start = (state == ST_CHK) && !drop;
    div_req.num_y = ny;
    div_req.num_z = nz;
    div_req.den   = (it.lorentz_factor < GAMMA_ONE) ? GAMMA_ONE : it.lorentz_factor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      step      <= '0;
      cell_idx  <= '0;
      acc_valid <= 1'b0;
      res_valid <= 1'b0;
      inv_len   <= 24'd65536;
      cps       <= 24'd65536;
      dom       <= '0;
    end else begin
      state     <= state_next;
      if (clearing) clr_addr <= clr_addr + 1'b1;
      step      <= (state == ST_SHAPE) ? step + 1'b1 : '0;
      cell_idx  <= (state == ST_CELL) ? cell_idx + 1'b1 : '0;
      acc_valid <= (state == ST_CELL);
      if (res_load) res_valid <= 1'b1;
      else if (results.ready) res_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_data.index)
          CFG_INV_CELL_LENGTH: inv_len <= cfg_data.value;
          CFG_CELL_PER_STEP:   cps     <= cfg_data.value;
          CFG_DOMAIN_START:    dom     <= cfg_data.value[19:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          it    <= q_entry.item;
          rd_ok <= q_entry.read_ok;
          cw    <= q_entry.item.particle_charge * $signed({1'b0, q_entry.item.particle_weight});
        end
      end
      ST_LOC: begin
        g_o <= it.old_position * $signed({1'b0, inv_len});
        g_n <= it.new_position * $signed({1'b0, inv_len});
        cxp <= cw * $signed({1'b0, cps});
        ny  <= cw * it.momentum_y;
        nz  <= cw * it.momentum_z;
      end
      ST_CHK: begin
        x_lane[0] <= $signed({~t_o[35], t_o[34:6]});
        x_lane[1] <= $signed({~t_n[35], t_n[34:6]});
        diff_r    <= diff[1:0];
        base_r    <= base[AW-1:0];
        crx       <= sat32(64'(cxp >>> 16));
      end
      ST_SHAPE: begin
        for (int l = 0; l < 2; l++) term[l][step] <= 32'(prod[l] >>> 30);
      end
      ST_SUM: begin
        for (int l = 0; l < 2; l++) begin
          for (int k = 0; k < 5; k++) shp[l][k] <= sums[l][k];
        end
      end
      ST_WAIT: begin
        cry <= div_rsp.q_y;
        crz <= div_rsp.q_z;
        cum <= '0;
      end
      ST_CELL: begin
        cum      <= cum + 34'(s0i) - 34'(s1i);
        acc_addr <= base_r + AW'(cell_idx);
        inc_x    <= 36'(px >>> 30);
        inc_y    <= 36'(py >>> 30);
        inc_z    <= 36'(pz >>> 30);
        inc_r    <= 36'(pr >>> 30);
      end
      default: ;
    endcase
    if (res_load) begin
      res_data.cell_number    <= it.read_cell;
      res_data.current_x      <= rd_ok ? rd_x : '0;
      res_data.current_y      <= rd_ok ? rd_y : '0;
      res_data.current_z      <= rd_ok ? rd_z : '0;
      res_data.charge_density <= rd_ok ? rd_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
      mem_z[wr_addr] <= wr_z;
      mem_r[wr_addr] <= wr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_x <= mem_x[rd_addr];
      rd_y <= mem_y[rd_addr];
      rd_z <= mem_z[rd_addr];
      rd_r <= mem_r[rd_addr];
    end
  end
endmodule
`default_nettype wire

// File: src/esirkepov_current_deposit_4th_order_1d.sv
// 1D charge-conserving current deposit, quartic shape, four grid memories.
// Deposit item: locate, range check (drop if out of range), shape, wait for the 52-step
// divider (transverse currents), then 7 cells read-modify-written at one per cycle plus one drain.
// Read item: grid read as it leaves the queue, result registered once the output is free.
// Reset clears control; a clearing pass then zeroes every grid cell,
// during which no item is accepted (config writes are). Uses ecd4_pkg, submodules.
`default_nettype none
module esirkepov_current_deposit_4th_order_1d import ecd4_pkg::*; #(
  parameter int GRID_CELLS = GRID_CELLS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  ecd4_chan_if.sink   items,
  ecd4_chan_if.source results,
  ecd4_chan_if.sink   cfg
);
  logic     clearing;
  logic     q_valid;
  logic     q_ready;
  entry_t   q_entry;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign cfg.ready = 1'b1;

  ecd4_front #(.GRID_CELLS(GRID_CELLS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .items    (items),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_entry  (q_entry)
  );

  ecd4_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  ecd4_back #(.GRID_CELLS(GRID_CELLS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_entry  (q_entry),
    .cfg_we   (cfg.valid),
    .cfg_data (cfg.data),
    .clearing (clearing),
    .div_req  (div_req),
    .div_rsp  (div_rsp),
    .results  (results)
  );
endmodule
`default_nettype wire

// File: src/ecd4_checker.sv
// Port-level checker for the current deposit block, bound to the top level.
// Uses ecd4_pkg and the assertion macro header.
`default_nettype none
`include "esirkepov_current_deposit_4th_order_1d_assert.svh"
module ecd4_checker import ecd4_pkg::*; #(
  parameter int GRID_CELLS = GRID_CELLS_DEFAULT
) (
  input logic    clk,
  input logic    rst,
  input logic    items_ready,
  input logic    results_valid,
  input logic    results_ready,
  input result_t results_data,
  input logic    cfg_ready
);
  `ECD4_ASSERT_NEXT(a_res_hold, results_valid && !results_ready, results_valid, "result dropped while stalled")
  `ECD4_ASSERT_NEXT(a_res_stable, results_valid && !results_ready, $stable(results_data), "result changed while stalled")
  `ECD4_ASSERT_NOW(a_clear_after_reset, $past(rst), !items_ready, "item accepted during grid clear")
  `ECD4_ASSERT_NOW(a_oob_zero, results_valid && (int'(results_data.cell_number) >= GRID_CELLS), (results_data.current_x == 0) && (results_data.current_y == 0) && (results_data.current_z == 0) && (results_data.charge_density == 0), "out-of-range read not zero")
  `ECD4_ASSERT_NOW(a_cfg_open, 1'b1, cfg_ready, "config port not ready")
endmodule

bind esirkepov_current_deposit_4th_order_1d ecd4_checker #(.GRID_CELLS(GRID_CELLS)) u_checker (
  .clk           (clk),
  .rst           (rst),
  .items_ready   (items.ready),
  .results_valid (results.valid),
  .results_ready (results.ready),
  .results_data  (results.data),
  .cfg_ready     (cfg.ready)
);
`default_nettype wire
